// ----- hw/rtl/stq_pkg.sv -----
// package: types, constants and combine functions for the sparse table range query block
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int DATA_WIDTH   = 32;
  localparam int NUM_LEVELS   = 11;
  localparam int IDX_W        = 10;
  localparam int CNT_W        = 11;
  localparam int LVL_W        = 4;
  localparam int ADDR_W       = LVL_W + IDX_W;
  localparam int MEM_DEPTH    = NUM_LEVELS * MAX_ELEMENTS;
  localparam int OP_W         = 3;
  localparam int STATUS_W     = 2;

  localparam logic [OP_W-1:0] OP_UMIN = 3'd0;
  localparam logic [OP_W-1:0] OP_UMAX = 3'd1;
  localparam logic [OP_W-1:0] OP_SMIN = 3'd2;
  localparam logic [OP_W-1:0] OP_SMAX = 3'd3;
  localparam logic [OP_W-1:0] OP_AND  = 3'd4;
  localparam logic [OP_W-1:0] OP_OR   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 2'd2;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [DATA_WIDTH-1:0] value;
    logic                  last;
    logic [CNT_W-1:0]      left;
    logic [CNT_W-1:0]      right;
  } stq_item_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] result;
    logic [STATUS_W-1:0]   status;
  } stq_rsp_t;

  typedef struct packed {
    logic load;
    logic query;
    logic build_read;
    logic level_next;
    logic build_done;
    logic result_load;
  } stq_cmd_t;

  typedef struct packed {
    logic lvl_empty;
    logic step_last;
    logic out_free;
  } stq_sts_t;

  function automatic logic [DATA_WIDTH-1:0] combine(input logic [DATA_WIDTH-1:0] a,
                                                    input logic [DATA_WIDTH-1:0] b,
                                                    input logic [OP_W-1:0] op);
    logic [DATA_WIDTH-1:0] r;
    case (op)
      OP_UMAX: r = (a > b) ? a : b;
      OP_SMIN: r = ($signed(a) < $signed(b)) ? a : b;
      OP_SMAX: r = ($signed(a) > $signed(b)) ? a : b;
      OP_AND:  r = a & b;
      OP_OR:   r = a | b;
      default: r = (a < b) ? a : b;
    endcase
    return r;
  endfunction

  function automatic logic [LVL_W-1:0] floor_log2(input logic [CNT_W-1:0] x);
    logic [LVL_W-1:0] k;
    k = '0;
    for (int i = 1; i < CNT_W; i++) begin
      if (x[i]) begin
        k = LVL_W'(i);
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/stq_ctrl.sv -----
// controller: sequences loads, table build levels and query results
`timescale 1ns / 1ps
`default_nettype none

module stq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  input  wire logic              item_kind,
  input  wire logic              item_last,
  output logic                   item_stall,
  input  wire stq_pkg::stq_sts_t sts,
  output stq_pkg::stq_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUILD,
    S_DRAIN,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = item_valid && !item_stall;

  always_comb begin
    cmd             = '0;
    cmd.load        = accept && (item_kind == stq_pkg::KIND_LOAD);
    cmd.query       = accept && (item_kind == stq_pkg::KIND_QUERY);
    cmd.build_read  = (state == S_BUILD) && !sts.lvl_empty;
    cmd.build_done  = (state == S_BUILD) && sts.lvl_empty;
    cmd.level_next  = (state == S_DRAIN);
    cmd.result_load = (state == S_RESULT) && sts.out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.load && item_last) begin
          state_next = S_BUILD;
        end else if (cmd.query) begin
          state_next = S_RESULT;
        end
      end
      S_BUILD: begin
        if (sts.lvl_empty) begin
          state_next = S_IDLE;
        end else if (sts.step_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_BUILD;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      item_stall <= 1'b0;
    end else begin
      state      <= state_next;
      item_stall <= (state_next != S_IDLE);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/stq_dp.sv -----
// datapath: level table memory, element count, build counters and result register
`timescale 1ns / 1ps
`default_nettype none

module stq_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire stq_pkg::stq_item_t          item,
  input  wire logic                        cfg_we,
  input  wire logic [stq_pkg::OP_W-1:0]    cfg_data,
  input  wire stq_pkg::stq_cmd_t           cmd,
  output stq_pkg::stq_sts_t                sts,
  output logic                             rsp_valid,
  input  wire logic                        rsp_stall,
  output stq_pkg::stq_rsp_t                rsp
);

  logic [stq_pkg::DATA_WIDTH-1:0] mem [0:stq_pkg::MEM_DEPTH-1];

  logic [stq_pkg::OP_W-1:0]       op;
  logic [stq_pkg::CNT_W-1:0]      count;
  logic                           ready;
  logic [stq_pkg::LVL_W-1:0]      lvl;
  logic [stq_pkg::IDX_W-1:0]      j;
  logic                           wr_pend;
  logic [stq_pkg::ADDR_W-1:0]     wr_addr;
  logic [stq_pkg::STATUS_W-1:0]   q_status;
  logic [stq_pkg::DATA_WIDTH-1:0] rdata_a;
  logic [stq_pkg::DATA_WIDTH-1:0] rdata_b;

  logic [stq_pkg::CNT_W-1:0]      half;
  logic [stq_pkg::CNT_W-1:0]      jb;
  logic [stq_pkg::CNT_W:0]        jn;
  logic [stq_pkg::CNT_W-1:0]      base;
  logic                           room;
  logic [stq_pkg::CNT_W-1:0]      qlen;
  logic [stq_pkg::LVL_W-1:0]      qk;
  logic [stq_pkg::CNT_W-1:0]      qother;
  logic [stq_pkg::STATUS_W-1:0]   qstat;
  logic [stq_pkg::ADDR_W-1:0]     raddr_a;
  logic [stq_pkg::ADDR_W-1:0]     raddr_b;
  logic [stq_pkg::ADDR_W-1:0]     waddr;
  logic [stq_pkg::DATA_WIDTH-1:0] wdata;
  logic                           we;
  logic                           re;

  // build pass bookkeeping
  assign half = stq_pkg::CNT_W'(1) << lvl;
  assign jb   = {1'b0, j} + half;
  assign jn   = {1'b0, jb} + 1'b1;

  assign sts.lvl_empty = (half >= count);
  assign sts.step_last = (jn >= {1'b0, count});
  assign sts.out_free  = !rsp_valid || !rsp_stall;

  // load placement
  assign base = ready ? '0 : count;
  assign room = (base < stq_pkg::CNT_W'(stq_pkg::MAX_ELEMENTS));

  // query decode
  assign qlen   = item.right - item.left;
  assign qk     = stq_pkg::floor_log2(qlen);
  assign qother = item.right - (stq_pkg::CNT_W'(1) << qk);

  always_comb begin
    if (!ready) begin
      qstat = stq_pkg::ST_NOT_BUILT;
    end else if ((item.left >= item.right) || (item.right > count)) begin
      qstat = stq_pkg::ST_RANGE;
    end else begin
      qstat = stq_pkg::ST_OK;
    end
  end

  always_comb begin
    if (cmd.build_read) begin
      raddr_a = {lvl, j};
      raddr_b = {lvl, jb[stq_pkg::IDX_W-1:0]};
    end else begin
      raddr_a = {qk, item.left[stq_pkg::IDX_W-1:0]};
      raddr_b = {qk, qother[stq_pkg::IDX_W-1:0]};
    end
  end

  assign re = cmd.build_read || cmd.query;

  always_comb begin
    if (wr_pend) begin
      we    = 1'b1;
      waddr = wr_addr;
      wdata = stq_pkg::combine(rdata_a, rdata_b, op);
    end else begin
      we    = cmd.load && room;
      waddr = {stq_pkg::LVL_W'(0), base[stq_pkg::IDX_W-1:0]};
      wdata = item.value;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op        <= stq_pkg::OP_UMIN;
      count     <= '0;
      ready     <= 1'b0;
      lvl       <= '0;
      j         <= '0;
      wr_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        op <= cfg_data;
      end
      if (cmd.load) begin
        ready <= 1'b0;
        count <= room ? base + 1'b1 : base;
        lvl   <= '0;
        j     <= '0;
      end
      if (cmd.build_read) begin
        j <= j + 1'b1;
      end
      if (cmd.level_next) begin
        lvl <= lvl + 1'b1;
        j   <= '0;
      end
      if (cmd.build_done) begin
        ready <= 1'b1;
      end
      wr_pend <= cmd.build_read;
      if (cmd.result_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= {stq_pkg::LVL_W'(lvl + 1'b1), j};
    if (cmd.query) begin
      q_status <= qstat;
    end
    if (cmd.result_load) begin
      rsp.status <= q_status;
      rsp.result <= (q_status == stq_pkg::ST_OK) ?
                    stq_pkg::combine(rdata_a, rdata_b, op) : '0;
    end
  end

  // build reads stay inside the loaded elements
  assert property (@(posedge clk) disable iff (rst)
    cmd.build_read |-> (jb < count))
    else $error("build read beyond element count");

  // a pending build write never meets a load write
  assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> !cmd.load)
    else $error("load during build write");

  // table becomes ready only at the end of a build
  assert property (@(posedge clk) disable iff (rst)
    $rose(ready) |-> $past(cmd.build_done))
    else $error("table ready without build");

  // a result never overwrites a word still held by the consumer
  assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> !(rsp_valid && rsp_stall))
    else $error("result register overwritten");

endmodule

`default_nettype wire

// ----- hw/rtl/sparse_table_range_query.sv -----
// top level: sparse table range query with configurable idempotent combine
//
//  channel | signals                         | word        | direction
//  item    | item_valid, item_stall, item    | stq_item_t  | in, stall out
//  rsp     | rsp_valid, rsp_stall, rsp       | stq_rsp_t   | out, stall in
//  cfg     | cfg_valid, cfg_ready, cfg_data  | combine_op  | in, ready out
//
// a load writes level 0 as it is accepted; a query is accepted with its table read, then its result is registered
// the last load starts a build: for each level with 2^i < n, reads on the two memory read ports
// for each j with j + 2^i < n, then a drain state, and a closing step; item_stall is high meanwhile
// rst is synchronous; the level table has no clearing pass and holds unwritten data
// a query result waits in its state while rsp_stall holds the output register
`timescale 1ns / 1ps
`default_nettype none

module sparse_table_range_query (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     item_valid,
  output logic                          item_stall,
  input  wire stq_pkg::stq_item_t       item,
  output logic                          rsp_valid,
  input  wire logic                     rsp_stall,
  output stq_pkg::stq_rsp_t             rsp,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [stq_pkg::OP_W-1:0] cfg_data
);

  stq_pkg::stq_cmd_t cmd;
  stq_pkg::stq_sts_t sts;
  logic              cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  stq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_kind  (item.kind),
    .item_last  (item.last),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  stq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
